/* rtl/core/fas_pkg.sv */
// ----------------------------------------------------------------------------
// fas_pkg: shared types and constants for the final approach sequencer
// Field widths, register reset values, step counts and the state encodings.
// ----------------------------------------------------------------------------
package fas_pkg;

    // Field and register widths
    localparam int POS_W       = 32;
    localparam int YAW_W       = 19;
    localparam int TIME_W      = 32;
    localparam int VEL_W       = 19;
    localparam int TURN_W      = 20;
    localparam int LIN_SPEED_W = 18;
    localparam int DURATION_W  = 24;
    localparam int MIN_DIST_W  = 17;
    localparam int ANG_TOL_W   = 18;
    localparam int ROT_SPEED_W = 19;
    localparam int CFG_DATA_W  = 24;
    localparam int CFG_IDX_W   = 3;

    // Datapath widths
    localparam int DIFF_W = POS_W + 1;            // goal minus robot
    localparam int SQ_W   = 2 * DIFF_W;           // sum of squares
    localparam int ROOT_W = DIFF_W;               // integer square root
    localparam int REM_W  = ROOT_W + 1;           // root / division remainder
    localparam int QUOT_W = LIN_SPEED_W + 1;      // quotient magnitude
    localparam int PROD_W = LIN_SPEED_W + DIFF_W; // speed times offset
    localparam int YERR_W = YAW_W + 1;            // yaw difference
    localparam int CNT_W  = 6;

    // Iteration counts of the serial units
    localparam int SQ_STEPS   = DIFF_W;
    localparam int ROOT_STEPS = ROOT_W;
    localparam int MUL_STEPS  = LIN_SPEED_W;
    localparam int DIV_STEPS  = QUOT_W;

    // Register reset values
    localparam logic [LIN_SPEED_W-1:0] LIN_SPEED_RST = LIN_SPEED_W'(6554);
    localparam logic [DURATION_W-1:0]  DURATION_RST  = DURATION_W'(1000000);
    localparam logic [MIN_DIST_W-1:0]  MIN_DIST_RST  = MIN_DIST_W'(655);
    localparam logic [ANG_TOL_W-1:0]   ANG_TOL_RST   = ANG_TOL_W'(6554);
    localparam logic [ROT_SPEED_W-1:0] ROT_SPEED_RST = ROT_SPEED_W'(19661);

    // Angles in Q16 radians
    localparam logic signed [YERR_W-1:0] YAW_PI     = YERR_W'(205887);
    localparam logic signed [YERR_W-1:0] YAW_TWO_PI = YERR_W'(411775);

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LIN_SPEED = 3'd0,
        CFG_DURATION  = 3'd1,
        CFG_MIN_DIST  = 3'd2,
        CFG_ANG_TOL   = 3'd3,
        CFG_ROT_SPEED = 3'd4
    } t_cfg_idx;

    // Approach phase
    typedef enum logic [1:0] {
        PH_IDLE     = 2'd0,
        PH_STRAIGHT = 2'd1,
        PH_ROTATE   = 2'd2
    } t_phase;

    // Sequencer states
    typedef enum logic [3:0] {
        S_IDLE,
        S_TIME,
        S_SQX,
        S_SQY,
        S_ROOT,
        S_NORM,
        S_MUL,
        S_DIVLD,
        S_DIV,
        S_WRAP,
        S_YAW,
        S_OUT
    } t_state;

    // Magnitude of a signed offset, as an unsigned value of the same width
    function automatic logic [DIFF_W-1:0] mag_diff(input logic [DIFF_W-1:0] v);
        mag_diff = v[DIFF_W-1] ? (~v + 1'b1) : v;
    endfunction

endpackage

/* rtl/core/final_approach_sequencer.sv */
// ----------------------------------------------------------------------------
// final_approach_sequencer: straight drive then heading alignment
// Turns robot and goal poses into a planar velocity command, one command
// per input beat, using bit-serial squaring, root, product and division units.
// ----------------------------------------------------------------------------
// Steps: straight commands pass the time check, two 33-step squarings, a 33-step
//   root, the distance check, two 18-step products and 19-step divisions each
//   with a load state, and the hand-over; rotate ones the wrap, yaw and hand-over.
// Flow: the next beat is taken once the result sits in the output register,
//   even while that result is stalled.
// Reset: synchronous, active low; idle phase, zero start time, default registers.
module final_approach_sequencer (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // input channel
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  logic signed [fas_pkg::POS_W-1:0]     i_robot_x,
    input  logic signed [fas_pkg::POS_W-1:0]     i_robot_y,
    input  logic signed [fas_pkg::YAW_W-1:0]     i_robot_yaw,
    input  logic signed [fas_pkg::POS_W-1:0]     i_goal_x,
    input  logic signed [fas_pkg::POS_W-1:0]     i_goal_y,
    input  logic signed [fas_pkg::YAW_W-1:0]     i_goal_yaw,
    input  logic        [fas_pkg::TIME_W-1:0]    i_time_now,
    // output channel
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output logic signed [fas_pkg::VEL_W-1:0]     o_vel_x,
    output logic signed [fas_pkg::VEL_W-1:0]     o_vel_y,
    output logic signed [fas_pkg::TURN_W-1:0]    o_vel_turn,
    output logic                                 o_completed,
    // configuration write port
    input  logic                                 i_cfg_we,
    input  logic        [fas_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic        [fas_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import fas_pkg::*;

    // Configuration
    logic [LIN_SPEED_W-1:0] r_lin_speed;
    logic [DURATION_W-1:0]  r_duration;
    logic [MIN_DIST_W-1:0]  r_min_dist;
    logic [ANG_TOL_W-1:0]   r_ang_tol;
    logic [ROT_SPEED_W-1:0] r_rot_speed;

    // Control
    t_state r_state, n_state;
    t_phase r_phase, n_phase;
    logic [TIME_W-1:0] r_start, n_start;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic              r_sel, n_sel;
    logic              r_out_valid, n_out_valid;

    // Captured beat
    logic signed [DIFF_W-1:0] r_dx, n_dx;
    logic signed [DIFF_W-1:0] r_dy, n_dy;
    logic signed [YERR_W-1:0] r_yerr, n_yerr;
    logic [TIME_W-1:0]        r_now, n_now;

    // Serial datapath
    logic [SQ_W-1:0]   r_acc, n_acc;
    logic [SQ_W-1:0]   r_mcand, n_mcand;
    logic [DIFF_W-1:0] r_mplr, n_mplr;
    logic [REM_W-1:0]  r_rem, n_rem;
    logic [ROOT_W-1:0] r_root, n_root;

    // Result under construction and output register
    logic signed [VEL_W-1:0]  r_vx, n_vx;
    logic signed [VEL_W-1:0]  r_vy, n_vy;
    logic signed [TURN_W-1:0] r_vt, n_vt;
    logic                     r_done, n_done;
    logic signed [VEL_W-1:0]  r_out_vx, n_out_vx;
    logic signed [VEL_W-1:0]  r_out_vy, n_out_vy;
    logic signed [TURN_W-1:0] r_out_vt, n_out_vt;
    logic                     r_out_done, n_out_done;

    // Combinational helpers
    logic                     w_in_acc;
    logic                     w_last;
    logic [DIFF_W-1:0]        w_ax, w_ay;
    logic [SQ_W-1:0]          w_add;
    logic [REM_W+1:0]         w_root_t, w_root_trial, w_root_sub;
    logic                     w_root_ge;
    logic [REM_W-1:0]         w_div_t, w_div_sub;
    logic                     w_div_ge;
    logic [QUOT_W-1:0]        w_quot, w_quot_s;
    logic                     w_neg;
    logic [TIME_W-1:0]        w_elapsed;
    logic signed [YERR_W-1:0] w_wrap;
    logic [YERR_W-1:0]        w_amag;
    logic                     w_turn;

    // Hold the input off while busy and while in reset
    assign o_in_stall  = (r_state != S_IDLE) || !i_rst_n;
    assign w_in_acc    = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_valid;
    assign o_vel_x     = r_out_vx;
    assign o_vel_y     = r_out_vy;
    assign o_vel_turn  = r_out_vt;
    assign o_completed = r_out_done;

    // Shared arithmetic
    always_comb begin
        w_last   = (r_cnt == CNT_W'(1));
        w_ax     = mag_diff(r_dx);
        w_ay     = mag_diff(r_dy);
        w_add    = r_acc + (r_mplr[0] ? r_mcand : '0);
        // one root digit: bring down two radicand bits, try 4*root+1
        w_root_t     = {r_rem, r_acc[SQ_W-1 -: 2]};
        w_root_trial = {1'b0, r_root, 2'b01};
        w_root_ge    = (w_root_t >= w_root_trial);
        w_root_sub   = w_root_t - w_root_trial;
        // one quotient bit: bring down a numerator bit, try the root
        w_div_t   = {r_rem[ROOT_W-1:0], r_acc[QUOT_W-1]};
        w_div_ge  = (w_div_t >= {1'b0, r_root});
        w_div_sub = w_div_t - {1'b0, r_root};
        w_quot    = {r_acc[QUOT_W-2:0], w_div_ge};
        w_neg     = r_sel ? r_dy[DIFF_W-1] : r_dx[DIFF_W-1];
        w_quot_s  = w_neg ? (~w_quot + 1'b1) : w_quot;
        w_elapsed = r_now - r_start;
        // wrap the yaw difference into [-pi, pi]
        if (r_yerr < -YAW_PI) begin
            w_wrap = r_yerr + YAW_TWO_PI;
        end else if (r_yerr > YAW_PI) begin
            w_wrap = r_yerr - YAW_TWO_PI;
        end else begin
            w_wrap = r_yerr;
        end
        w_amag = r_yerr[YERR_W-1] ? YERR_W'(-r_yerr) : YERR_W'(r_yerr);
        w_turn = (w_amag > {{(YERR_W-ANG_TOL_W){1'b0}}, r_ang_tol});
    end

    // Next state and datapath
    always_comb begin
        n_state     = r_state;
        n_phase     = r_phase;
        n_start     = r_start;
        n_cnt       = r_cnt;
        n_sel       = r_sel;
        n_dx        = r_dx;
        n_dy        = r_dy;
        n_yerr      = r_yerr;
        n_now       = r_now;
        n_acc       = r_acc;
        n_mcand     = r_mcand;
        n_mplr      = r_mplr;
        n_rem       = r_rem;
        n_root      = r_root;
        n_vx        = r_vx;
        n_vy        = r_vy;
        n_vt        = r_vt;
        n_done      = r_done;
        n_out_vx    = r_out_vx;
        n_out_vy    = r_out_vy;
        n_out_vt    = r_out_vt;
        n_out_done  = r_out_done;
        n_out_valid = r_out_valid && i_out_stall;

        case (r_state)
            // Capture the beat; a fresh approach records its start time
            S_IDLE: begin
                if (w_in_acc) begin
                    n_dx   = {i_goal_x[POS_W-1], i_goal_x} - {i_robot_x[POS_W-1], i_robot_x};
                    n_dy   = {i_goal_y[POS_W-1], i_goal_y} - {i_robot_y[POS_W-1], i_robot_y};
                    n_yerr = {i_goal_yaw[YAW_W-1], i_goal_yaw}
                           - {i_robot_yaw[YAW_W-1], i_robot_yaw};
                    n_now  = i_time_now;
                    case (r_phase)
                        PH_STRAIGHT: n_state = S_TIME;
                        PH_ROTATE:   n_state = S_WRAP;
                        default: begin
                            n_start = i_time_now;
                            n_phase = PH_STRAIGHT;
                            n_state = S_TIME;
                        end
                    endcase
                end
            end
            // Check the time budget; start squaring the x offset, or rotate once time is up
            S_TIME: begin
                if (w_elapsed < {{(TIME_W-DURATION_W){1'b0}}, r_duration}) begin
                    n_acc   = '0;
                    n_mcand = {{(SQ_W-DIFF_W){1'b0}}, w_ax};
                    n_mplr  = w_ax;
                    n_cnt   = CNT_W'(SQ_STEPS);
                    n_state = S_SQX;
                end else begin
                    n_phase = PH_ROTATE;
                    n_state = S_WRAP;
                end
            end
            // Shift-add squaring, x then y into the same accumulator
            S_SQX, S_SQY: begin
                n_acc   = w_add;
                n_mcand = r_mcand << 1;
                n_mplr  = r_mplr >> 1;
                n_cnt   = r_cnt - 1'b1;
                if (w_last) begin
                    if (r_state == S_SQX) begin
                        n_mcand = {{(SQ_W-DIFF_W){1'b0}}, w_ay};
                        n_mplr  = w_ay;
                        n_cnt   = CNT_W'(SQ_STEPS);
                        n_state = S_SQY;
                    end else begin
                        n_rem   = '0;
                        n_root  = '0;
                        n_cnt   = CNT_W'(ROOT_STEPS);
                        n_state = S_ROOT;
                    end
                end
            end
            // Restoring square root, one digit a cycle from the top
            S_ROOT: begin
                n_acc = r_acc << 2;
                n_cnt = r_cnt - 1'b1;
                if (w_root_ge) begin
                    n_rem  = w_root_sub[REM_W-1:0];
                    n_root = {r_root[ROOT_W-2:0], 1'b1};
                end else begin
                    n_rem  = w_root_t[REM_W-1:0];
                    n_root = {r_root[ROOT_W-2:0], 1'b0};
                end
                if (w_last) begin
                    n_state = S_NORM;
                end
            end
            // Distance check; start speed times x offset, or rotate once close enough
            S_NORM: begin
                if (r_root > {{(ROOT_W-MIN_DIST_W){1'b0}}, r_min_dist}) begin
                    n_sel   = 1'b0;
                    n_acc   = '0;
                    n_mcand = {{(SQ_W-DIFF_W){1'b0}}, w_ax};
                    n_mplr  = {{(DIFF_W-LIN_SPEED_W){1'b0}}, r_lin_speed};
                    n_cnt   = CNT_W'(MUL_STEPS);
                    n_state = S_MUL;
                end else begin
                    n_phase = PH_ROTATE;
                    n_state = S_WRAP;
                end
            end
            // Shift-add product of speed and offset magnitude
            S_MUL: begin
                n_acc   = w_add;
                n_mcand = r_mcand << 1;
                n_mplr  = r_mplr >> 1;
                n_cnt   = r_cnt - 1'b1;
                if (w_last) begin
                    n_state = S_DIVLD;
                end
            end
            // Seed the remainder with the product bits above the quotient
            S_DIVLD: begin
                n_rem   = REM_W'(r_acc[PROD_W-1:QUOT_W]);
                n_cnt   = CNT_W'(DIV_STEPS);
                n_state = S_DIV;
            end
            // Restoring division by the distance, one quotient bit a cycle
            S_DIV: begin
                n_rem = w_div_ge ? w_div_sub : w_div_t;
                n_acc = {r_acc[SQ_W-2:0], w_div_ge};
                n_cnt = r_cnt - 1'b1;
                if (w_last) begin
                    if (!r_sel) begin
                        n_vx    = w_quot_s;
                        n_sel   = 1'b1;
                        n_acc   = '0;
                        n_mcand = {{(SQ_W-DIFF_W){1'b0}}, w_ay};
                        n_mplr  = {{(DIFF_W-LIN_SPEED_W){1'b0}}, r_lin_speed};
                        n_cnt   = CNT_W'(MUL_STEPS);
                        n_state = S_MUL;
                    end else begin
                        n_vy    = w_quot_s;
                        n_vt    = '0;
                        n_done  = 1'b0;
                        n_state = S_OUT;
                    end
                end
            end
            // Wrap the heading error
            S_WRAP: begin
                n_yerr  = w_wrap;
                n_state = S_YAW;
            end
            // Turn toward the goal heading or finish the approach
            S_YAW: begin
                n_vx = '0;
                n_vy = '0;
                if (w_turn) begin
                    if (!r_yerr[YERR_W-1] && (r_yerr != '0)) begin
                        n_vt = {1'b0, r_rot_speed};
                    end else begin
                        n_vt = ~{1'b0, r_rot_speed} + 1'b1;
                    end
                    n_done = 1'b0;
                end else begin
                    n_vt    = '0;
                    n_done  = 1'b1;
                    n_phase = PH_IDLE;
                end
                n_state = S_OUT;
            end
            // Hand the result to the output register once it is free
            S_OUT: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_vx    = r_vx;
                    n_out_vy    = r_vy;
                    n_out_vt    = r_vt;
                    n_out_done  = r_done;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_phase     <= PH_IDLE;
            r_start     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_phase     <= n_phase;
            r_start     <= n_start;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_cnt      <= n_cnt;
        r_sel      <= n_sel;
        r_dx       <= n_dx;
        r_dy       <= n_dy;
        r_yerr     <= n_yerr;
        r_now      <= n_now;
        r_acc      <= n_acc;
        r_mcand    <= n_mcand;
        r_mplr     <= n_mplr;
        r_rem      <= n_rem;
        r_root     <= n_root;
        r_vx       <= n_vx;
        r_vy       <= n_vy;
        r_vt       <= n_vt;
        r_done     <= n_done;
        r_out_vx   <= n_out_vx;
        r_out_vy   <= n_out_vy;
        r_out_vt   <= n_out_vt;
        r_out_done <= n_out_done;
    end

    // Configuration writes; unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lin_speed <= LIN_SPEED_RST;
            r_duration  <= DURATION_RST;
            r_min_dist  <= MIN_DIST_RST;
            r_ang_tol   <= ANG_TOL_RST;
            r_rot_speed <= ROT_SPEED_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_LIN_SPEED: r_lin_speed <= i_cfg_data[LIN_SPEED_W-1:0];
                CFG_DURATION:  r_duration  <= i_cfg_data[DURATION_W-1:0];
                CFG_MIN_DIST:  r_min_dist  <= i_cfg_data[MIN_DIST_W-1:0];
                CFG_ANG_TOL:   r_ang_tol   <= i_cfg_data[ANG_TOL_W-1:0];
                CFG_ROT_SPEED: r_rot_speed <= i_cfg_data[ROT_SPEED_W-1:0];
                default: begin
                end
            endcase
        end
    end

endmodule

/* dv/tb_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the final approach sequencer
// Drives pose beats with bursty timing against a stalling receiver, keeps its
// own copy of the phase, start time and registers, and compares every
// velocity command field by field. Runs a directed opening, then approach
// episodes mixed with noise over several register settings.
// ----------------------------------------------------------------------------
module tb_top;

    import fas_pkg::*;

    localparam int CYCLE_LIMIT = 2000000;
    localparam int HOLD_CYCLES = 600;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;

    typedef struct packed {
        logic signed [POS_W-1:0] robot_x;
        logic signed [POS_W-1:0] robot_y;
        logic signed [YAW_W-1:0] robot_yaw;
        logic signed [POS_W-1:0] goal_x;
        logic signed [POS_W-1:0] goal_y;
        logic signed [YAW_W-1:0] goal_heading;
        logic [TIME_W-1:0]       time_now;
    } t_pose_beat;

    typedef struct packed {
        logic signed [VEL_W-1:0]  vel_x;
        logic signed [VEL_W-1:0]  vel_y;
        logic signed [TURN_W-1:0] vel_turn;
        logic                     completed;
    } t_vel_cmd;

    typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_TOGGLE} t_stall_mode;

    // ------------------------------------------------------------------------
    // Command predictor and store of expected commands
    // ------------------------------------------------------------------------
    class t_approach_scoreboard;
        t_phase                 phase;
        logic [TIME_W-1:0]      start_time;
        logic [LIN_SPEED_W-1:0] lin_speed;
        logic [DURATION_W-1:0]  duration;
        logic [MIN_DIST_W-1:0]  min_dist;
        logic [ANG_TOL_W-1:0]   ang_tol;
        logic [ROT_SPEED_W-1:0] rot_speed;
        t_vel_cmd               expected_cmds[$];
        int                     errors;

        function new();
            phase      = PH_IDLE;
            start_time = '0;
            lin_speed  = LIN_SPEED_RST;
            duration   = DURATION_RST;
            min_dist   = MIN_DIST_RST;
            ang_tol    = ANG_TOL_RST;
            rot_speed  = ROT_SPEED_RST;
            errors     = 0;
        endfunction

        // Mirror a register write; unknown indexes are dropped
        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_LIN_SPEED: lin_speed = data[LIN_SPEED_W-1:0];
                CFG_DURATION:  duration  = data[DURATION_W-1:0];
                CFG_MIN_DIST:  min_dist  = data[MIN_DIST_W-1:0];
                CFG_ANG_TOL:   ang_tol   = data[ANG_TOL_W-1:0];
                CFG_ROT_SPEED: rot_speed = data[ROT_SPEED_W-1:0];
                default: ;
            endcase
        endfunction

        // Largest root whose square fits, built from the top bit down
        function logic [ROOT_W-1:0] floor_root(logic [SQ_W-1:0] v);
            logic [ROOT_W-1:0] r;
            logic [ROOT_W-1:0] c;
            logic [SQ_W+1:0]   sq;
            r = '0;
            for (int k = ROOT_W - 1; k >= 0; k--) begin
                c  = r | (ROOT_W'(1) << k);
                sq = {2'b00, {ROOT_W{1'b0}}, c} * {2'b00, {ROOT_W{1'b0}}, c};
                if (sq <= {2'b00, v}) begin
                    r = c;
                end
            end
            return r;
        endfunction

        // Work out the command for one beat and advance the phase
        function t_vel_cmd predict_cmd(t_pose_beat b);
            t_vel_cmd          cmd;
            longint            dx;
            longint            dy;
            longint            yerr;
            logic [DIFF_W-1:0] ax;
            logic [DIFF_W-1:0] ay;
            logic [SQ_W-1:0]   sum;
            logic [ROOT_W-1:0] norm;
            logic [TIME_W-1:0] elapsed;
            cmd  = '0;
            dx   = longint'($signed(b.goal_x)) - longint'($signed(b.robot_x));
            dy   = longint'($signed(b.goal_y)) - longint'($signed(b.robot_y));
            ax   = DIFF_W'(dx < 0 ? -dx : dx);
            ay   = DIFF_W'(dy < 0 ? -dy : dy);
            sum  = {{DIFF_W{1'b0}}, ax} * {{DIFF_W{1'b0}}, ax}
                 + {{DIFF_W{1'b0}}, ay} * {{DIFF_W{1'b0}}, ay};
            norm = floor_root(sum);

            // Leave idle: latch the start time
            if (phase != PH_STRAIGHT && phase != PH_ROTATE) begin
                start_time = b.time_now;
                phase      = PH_STRAIGHT;
            end

            // Drive toward the goal until time runs out or the goal is close
            if (phase == PH_STRAIGHT) begin
                elapsed = b.time_now - start_time;
                if (elapsed < TIME_W'(duration) && norm > ROOT_W'(min_dist)) begin
                    cmd.vel_x = VEL_W'((longint'(lin_speed) * dx) / longint'(norm));
                    cmd.vel_y = VEL_W'((longint'(lin_speed) * dy) / longint'(norm));
                end else begin
                    phase = PH_ROTATE;
                end
            end

            // Turn toward the wrapped heading error, finish once within tolerance
            if (phase == PH_ROTATE) begin
                yerr = (longint'($signed(b.goal_heading)) - longint'($signed(b.robot_yaw))
                        + longint'(YAW_PI)) % longint'(YAW_TWO_PI);
                if (yerr < 0) begin
                    yerr += longint'(YAW_TWO_PI);
                end
                yerr -= longint'(YAW_PI);
                if ((yerr < 0 ? -yerr : yerr) > longint'(ang_tol)) begin
                    cmd.vel_turn = TURN_W'(yerr > 0 ? longint'(rot_speed)
                                                    : -longint'(rot_speed));
                end else begin
                    cmd.completed = 1'b1;
                    phase         = PH_IDLE;
                end
            end
            return cmd;
        endfunction

        function void note_beat(t_pose_beat b);
            expected_cmds = {expected_cmds, predict_cmd(b)};
        endfunction

        function void flag_field(string field, logic signed [TURN_W-1:0] want_v,
                                 logic signed [TURN_W-1:0] got_v);
            errors++;
            $display("%0t: %s mismatch, expected %0d, actual %0d",
                     $time, field, want_v, got_v);
        endfunction

        function void check_cmd(t_vel_cmd got);
            t_vel_cmd want;
            if (expected_cmds.size() == 0) begin
                errors++;
                $display("%0t: command with no beat pending", $time);
                return;
            end
            want = expected_cmds.pop_front();
            if (got.vel_x !== want.vel_x) begin
                flag_field("vel_x", TURN_W'(want.vel_x), TURN_W'(got.vel_x));
            end
            if (got.vel_y !== want.vel_y) begin
                flag_field("vel_y", TURN_W'(want.vel_y), TURN_W'(got.vel_y));
            end
            if (got.vel_turn !== want.vel_turn) begin
                flag_field("vel_turn", want.vel_turn, got.vel_turn);
            end
            if (got.completed !== want.completed) begin
                flag_field("completed", TURN_W'(want.completed), TURN_W'(got.completed));
            end
        endfunction

        function int pending();
            return expected_cmds.size();
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset and block inputs
    // ------------------------------------------------------------------------
    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    logic                          i_in_valid  = 1'b0;
    logic                          o_in_stall;
    logic signed [POS_W-1:0]       i_robot_x   = '0;
    logic signed [POS_W-1:0]       i_robot_y   = '0;
    logic signed [YAW_W-1:0]       i_robot_yaw = '0;
    logic signed [POS_W-1:0]       i_goal_x    = '0;
    logic signed [POS_W-1:0]       i_goal_y    = '0;
    logic signed [YAW_W-1:0]       i_goal_yaw  = '0;
    logic [TIME_W-1:0]             i_time_now  = '0;
    logic                          o_out_valid;
    logic                          i_out_stall = 1'b0;
    logic signed [VEL_W-1:0]       o_vel_x;
    logic signed [VEL_W-1:0]       o_vel_y;
    logic signed [TURN_W-1:0]      o_vel_turn;
    logic                          o_completed;
    logic                          i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]          i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]         i_cfg_data  = '0;

    always #4 i_clk = ~i_clk;

    final_approach_sequencer dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_robot_x   (i_robot_x),
        .i_robot_y   (i_robot_y),
        .i_robot_yaw (i_robot_yaw),
        .i_goal_x    (i_goal_x),
        .i_goal_y    (i_goal_y),
        .i_goal_yaw  (i_goal_yaw),
        .i_time_now  (i_time_now),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_vel_x     (o_vel_x),
        .o_vel_y     (o_vel_y),
        .o_vel_turn  (o_vel_turn),
        .o_completed (o_completed),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    t_approach_scoreboard sb;

    // Approach episode state for the random part
    logic signed [POS_W-1:0] ep_goal_x;
    logic signed [POS_W-1:0] ep_goal_y;
    logic signed [POS_W-1:0] ep_off_x;
    logic signed [POS_W-1:0] ep_off_y;
    longint                  ep_goal_heading;
    longint                  ep_yaw_err;
    logic [TIME_W-1:0]       ep_time;
    int                      ep_left    = 0;
    logic [DURATION_W-1:0]   cur_dur    = DURATION_RST;
    int                      burst_left = 0;

    // Receiver state
    t_vel_cmd    got_cmd;
    int          cmds_taken = 0;
    int          hold_left  = 0;
    int          mode_left  = 0;
    t_stall_mode stall_mode = STALL_NONE;

    function automatic t_pose_beat pose_beat(
        input logic signed [POS_W-1:0] rx, ry, input logic signed [YAW_W-1:0] ryaw,
        input logic signed [POS_W-1:0] gx, gy, input logic signed [YAW_W-1:0] gyaw,
        input logic [TIME_W-1:0] t);
        t_pose_beat b;
        b.robot_x      = rx;
        b.robot_y      = ry;
        b.robot_yaw    = ryaw;
        b.goal_x       = gx;
        b.goal_y       = gy;
        b.goal_heading = gyaw;
        b.time_now     = t;
        return b;
    endfunction

    // Offer one beat and hold it until taken
    task automatic drive_beat(input t_pose_beat b);
        i_in_valid  <= 1'b1;
        i_robot_x   <= b.robot_x;
        i_robot_y   <= b.robot_y;
        i_robot_yaw <= b.robot_yaw;
        i_goal_x    <= b.goal_x;
        i_goal_y    <= b.goal_y;
        i_goal_yaw  <= b.goal_heading;
        i_time_now  <= b.time_now;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        sb.note_beat(b);
    endtask

    // Send in bursts, with a random gap before each new burst
    task automatic offer_beat(input t_pose_beat b);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            case ($urandom_range(0, 9))
                0, 1, 2: gap = 0;
                3:       gap = $urandom_range(17, 250);
                default: gap = $urandom_range(1, 16);
            endcase
            if (gap != 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        drive_beat(b);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        sb.write_reg(idx, data);
    endtask

    // Mostly approach episodes that close in on the goal, the rest noise
    task automatic make_random_beat(output t_pose_beat b);
        int                scale;
        logic [TIME_W-1:0] step;
        if ($urandom_range(0, 3) == 0) begin
            b.robot_x      = $urandom;
            b.robot_y      = $urandom;
            b.robot_yaw    = YAW_W'($urandom);
            b.goal_x       = $urandom;
            b.goal_y       = $urandom;
            b.goal_heading = YAW_W'($urandom);
            b.time_now     = $urandom;
            return;
        end
        if (ep_left == 0) begin
            ep_left         = $urandom_range(2, 14);
            ep_goal_x       = $signed($urandom) >>> $urandom_range(0, 12);
            ep_goal_y       = $signed($urandom) >>> $urandom_range(0, 12);
            scale           = $urandom_range(0, 31);
            ep_off_x        = $signed($urandom) >>> (31 - scale);
            scale           = $urandom_range(0, 31);
            ep_off_y        = $signed($urandom) >>> (31 - scale);
            ep_goal_heading = longint'($urandom_range(0, 411774)) - longint'(YAW_PI);
            ep_yaw_err      = longint'($urandom_range(0, 411774)) - longint'(YAW_PI);
            ep_time         = ($urandom_range(0, 7) == 0) ? ~TIME_W'($urandom_range(0, 100000))
                                                          : TIME_W'($urandom);
        end else begin
            ep_left--;
            ep_off_x = ep_off_x >>> $urandom_range(0, 2);
            ep_off_y = ep_off_y >>> $urandom_range(0, 2);
            if ($urandom_range(0, 3) != 0) begin
                ep_yaw_err = ep_yaw_err / 2;
            end
            step    = ($urandom_range(0, 9) == 0) ? TIME_W'($urandom)
                    : TIME_W'($urandom_range(0, (int'(cur_dur) >> 2) + 1));
            ep_time = ep_time + step;
        end
        b.robot_x      = ep_goal_x - ep_off_x;
        b.robot_y      = ep_goal_y - ep_off_y;
        b.robot_yaw    = YAW_W'(ep_goal_heading - ep_yaw_err);
        b.goal_x       = ep_goal_x;
        b.goal_y       = ep_goal_y;
        b.goal_heading = YAW_W'(ep_goal_heading);
        b.time_now     = ep_time;
    endtask

    // ------------------------------------------------------------------------
    // Receiver: take commands, stall on its own pattern, hold off twice
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            got_cmd.vel_x     = o_vel_x;
            got_cmd.vel_y     = o_vel_y;
            got_cmd.vel_turn  = o_vel_turn;
            got_cmd.completed = o_completed;
            sb.check_cmd(got_cmd);
            cmds_taken++;
            if (cmds_taken == 150 || cmds_taken == 550) begin
                hold_left = HOLD_CYCLES;
            end
        end
        if (mode_left == 0) begin
            stall_mode = t_stall_mode'($urandom_range(0, 3));
            mode_left  = $urandom_range(50, 400);
        end
        mode_left--;
        if (hold_left != 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else begin
            case (stall_mode)
                STALL_NONE:  i_out_stall <= 1'b0;
                STALL_LIGHT: i_out_stall <= ($urandom_range(0, 3) == 0);
                STALL_HEAVY: i_out_stall <= ($urandom_range(0, 3) != 0);
                default:     i_out_stall <= ~i_out_stall;
            endcase
        end
    end

    // Watchdog
    initial begin : watchdog
        int cycle_count;
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("RESULT: ERROR");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial begin : stimulus
        t_pose_beat            b;
        logic [CFG_DATA_W-1:0] lin;
        logic [CFG_DATA_W-1:0] dur;
        logic [CFG_DATA_W-1:0] mind;
        logic [CFG_DATA_W-1:0] tol;
        logic [CFG_DATA_W-1:0] rot;
        int                    n_beats;

        sb = new();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed opening under reset settings
        // start straight, then extreme offsets with a carry out of the square sum
        drive_beat(pose_beat(0, 0, 19'sd0, 32'sd65536, 0, 19'sd100000, 32'd100));
        drive_beat(pose_beat(32'sh8000_0000, 32'sh7FFF_FFFF, 19'sd0,
                             32'sh7FFF_FFFF, 32'sh8000_0000, 19'sd0, 32'd5000));
        drive_beat(pose_beat(32'sh7FFF_FFFF, 32'sh8000_0000, 19'sd0,
                             32'sh8000_0000, 32'sh7FFF_FFFF, 19'sd0, 32'd9000));
        // distance equal to the minimum ends the straight run, turn both ways
        drive_beat(pose_beat(0, 0, 19'sd0, 32'sd655, 0, 19'sd150000, 32'd10000));
        drive_beat(pose_beat(0, 0, 19'sd0, 0, 0, -19'sd150000, 32'd20000));
        // error exactly at tolerance completes
        drive_beat(pose_beat(0, 0, 19'sd0, 0, 0, 19'sd6554, 32'd30000));
        // start just before the time wrap, keep going across it
        drive_beat(pose_beat(0, 0, 19'sd0, 32'sd196608, -32'sd262144, 19'sd0,
                             32'hFFFF_FF00));
        drive_beat(pose_beat(32'sd65536, 32'sd65536, 19'sd0, 0, 0, 19'sd0,
                             32'h0000_0100));
        // elapsed equal to the duration ends the straight run
        drive_beat(pose_beat(0, 0, 19'sd0, 32'sd1048576, 0, 19'sd6555, 32'h000F_4140));
        // yaw extremes wrap to a tiny error
        drive_beat(pose_beat(0, 0, -19'sd205887, 0, 0, 19'sd205887, 32'h000F_5000));
        drive_beat(pose_beat(0, 0, 19'sd0, 32'sd656, 0, 19'sd0, 32'd5));
        // zero distance, yaw patterns outside the heading range
        drive_beat(pose_beat(0, 0, 19'sh40000, 0, 0, 19'sh3FFFF, 32'd10));
        // error of minus and plus half a turn
        drive_beat(pose_beat(0, 0, 19'sd205887, 0, 0, 19'sd0, 32'd20));
        drive_beat(pose_beat(0, 0, 19'sd0, 0, 0, 19'sd205887, 32'd30));
        drive_beat(pose_beat(0, 0, 19'sd1000, 0, 0, 19'sd1000, 32'd40));
        // done straight from idle
        drive_beat(pose_beat(32'sd5, 32'sd5, 19'sd0, 32'sd5, 32'sd5, 19'sd0, 32'd0));
        drive_beat(pose_beat(0, 0, 19'sd0, -32'sd65536, 32'sd131072, 19'sd0,
                             32'hFFFF_FFFF));
        drive_beat(pose_beat(-32'sd1, -32'sd1, -19'sd205887, 0, 0, 19'sd205887,
                             32'd999998));

        // Random part over several register settings
        for (int ph = 0; ph < 8; ph++) begin
            i_in_valid <= 1'b0;
            while (sb.pending() != 0) @(posedge i_clk);
            case (ph)
                0: begin
                    lin  = CFG_DATA_W'(131072);
                    dur  = CFG_DATA_W'(16777215);
                    mind = CFG_DATA_W'(65536);
                    tol  = CFG_DATA_W'(205887);
                    rot  = CFG_DATA_W'(262144);
                end
                1: begin
                    lin  = '0;
                    dur  = '0;
                    mind = '0;
                    tol  = '0;
                    rot  = '0;
                end
                default: begin
                    lin = CFG_DATA_W'($urandom_range(0, 131072));
                    case ($urandom_range(0, 2))
                        0:       dur = CFG_DATA_W'($urandom_range(1, 5000));
                        1:       dur = CFG_DATA_W'($urandom_range(5000, 2000000));
                        default: dur = CFG_DATA_W'($urandom_range(0, 16777215));
                    endcase
                    mind = ($urandom_range(0, 3) == 0) ? CFG_DATA_W'($urandom_range(0, 65536))
                                                       : CFG_DATA_W'($urandom_range(0, 4096));
                    tol  = ($urandom_range(0, 3) == 0) ? CFG_DATA_W'($urandom_range(0, 205887))
                                                       : CFG_DATA_W'($urandom_range(0, 20000));
                    rot  = CFG_DATA_W'($urandom_range(0, 262144));
                end
            endcase
            if (ph == 0) begin
                write_reg(CFG_UNUSED, CFG_DATA_W'($urandom));
            end
            write_reg(CFG_LIN_SPEED, lin);
            write_reg(CFG_DURATION, dur);
            write_reg(CFG_MIN_DIST, mind);
            write_reg(CFG_ANG_TOL, tol);
            write_reg(CFG_ROT_SPEED, rot);
            i_cfg_we <= 1'b0;
            cur_dur  = dur[DURATION_W-1:0];
            n_beats  = (ph == 0) ? 100 : (ph == 1) ? 60 : 115;
            repeat (n_beats) begin
                make_random_beat(b);
                offer_beat(b);
            end
        end

        // Drain, then allow for a late extra command
        i_in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
